// ===== rtl/tswtm_pkg.sv =====
// Shared types and constants of the sliding-window throughput meter.
package tswtm_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = RING_AW + 1;
   localparam int NUM_LINKS  = 2;
   localparam int LINK_W     = 1;
   localparam int TIME_W     = 48;
   localparam int BYTES_W    = 28;
   localparam int PKTS_W     = 13;
   localparam int RATE_W     = 40;
   localparam int SUM_W      = 30;
   localparam int PROD_W     = SUM_W + 23;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW   = 2;

   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
   localparam logic [22:0] BITS_PER_SEC  = 23'd8000000;
   localparam logic [15:0] PORT0_RESET   = 16'd5051;
   localparam logic [15:0] PORT1_RESET   = 16'd5052;
   localparam logic [31:0] WINDOW_RESET  = 32'd2000000;

   localparam logic [1:0] REG_PORT0  = 2'd0;
   localparam logic [1:0] REG_PORT1  = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_BAD_IP    = 3'd1,
      ST_NOT_TCP   = 3'd2,
      ST_BAD_TCP   = 3'd3,
      ST_PORT_MISS = 3'd4,
      ST_QUERY     = 3'd5
   } status_type;

   // Classified job passed from the front end to the back end.
   typedef struct packed {
      logic              query;
      logic [LINK_W-1:0] link;
      status_type        status;
      logic [15:0]       payload;
      logic [TIME_W-1:0] time_us;
   } job_type;

endpackage

// ===== rtl/tswtm_front.sv =====
// Front end: checks headers, works out payload and queues classified jobs.
module tswtm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic                          req_link_id,
   input  logic [3:0]                    req_ip_header_words,
   input  logic [7:0]                    req_ip_protocol,
   input  logic [15:0]                   req_ip_total_length,
   input  logic [3:0]                    req_tcp_offset_words,
   input  logic [15:0]                   req_source_port,
   input  logic [tswtm_pkg::TIME_W-1:0]  req_time_us,
   input  logic [15:0]                   port0,
   input  logic [15:0]                   port1,
   output logic                          job_valid,
   output tswtm_pkg::job_type            job,
   input  logic                          job_take
);

   tswtm_pkg::job_type q_ff [tswtm_pkg::QUEUE_DEPTH];
   logic [tswtm_pkg::QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [tswtm_pkg::QUEUE_AW:0]   cnt_ff, cnt_in;
   tswtm_pkg::job_type nj;
   logic [6:0] hdrs;
   logic       push_ok;

   always_comb begin
      hdrs = {1'b0, req_ip_header_words, 2'b00} + {1'b0, req_tcp_offset_words, 2'b00};
      nj.query   = req_kind;
      nj.link    = req_link_id;
      nj.time_us = req_time_us;
      nj.payload = (req_ip_total_length > {9'd0, hdrs}) ?
                   (req_ip_total_length - {9'd0, hdrs}) : 16'd0;
      if (req_kind)
         nj.status = tswtm_pkg::ST_QUERY;
      else if (req_ip_header_words < tswtm_pkg::MIN_HDR_WORDS)
         nj.status = tswtm_pkg::ST_BAD_IP;
      else if (req_ip_protocol != tswtm_pkg::PROTO_TCP)
         nj.status = tswtm_pkg::ST_NOT_TCP;
      else if (req_tcp_offset_words < tswtm_pkg::MIN_HDR_WORDS)
         nj.status = tswtm_pkg::ST_BAD_TCP;
      else if (req_source_port != (req_link_id ? port1 : port0))
         nj.status = tswtm_pkg::ST_PORT_MISS;
      else
         nj.status = tswtm_pkg::ST_STORED;
   end

   assign req_full  = (cnt_ff == (tswtm_pkg::QUEUE_AW+1)'(tswtm_pkg::QUEUE_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + (tswtm_pkg::QUEUE_AW)'(push_ok);
      rd_in  = rd_ff + (tswtm_pkg::QUEUE_AW)'(job_take);
      cnt_in = cnt_ff + (tswtm_pkg::QUEUE_AW+1)'(push_ok)
                      - (tswtm_pkg::QUEUE_AW+1)'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) q_ff[wr_ff] <= nj;
   end

`ifndef SYNTH
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("job taken from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (tswtm_pkg::QUEUE_AW+1)'(tswtm_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !job_take) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/tswtm_back.sv =====
// Back end: ring store, ring walk for queries, rate arithmetic and result register.
module tswtm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  tswtm_pkg::job_type            job,
   output logic                          job_take,
   input  logic [31:0]                   window_us,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_status,
   output logic [tswtm_pkg::BYTES_W-1:0] rsp_window_bytes,
   output logic [tswtm_pkg::PKTS_W-1:0]  rsp_window_packets,
   output logic [tswtm_pkg::RATE_W-1:0]  rsp_bit_rate,
   output logic [tswtm_pkg::TIME_W-1:0]  rsp_first_time
);

   localparam int AW  = tswtm_pkg::RING_AW;
   localparam int MAW = tswtm_pkg::LINK_W + AW;
   localparam int TW  = tswtm_pkg::TIME_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_CHK  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_OUT  = 7'b0100000,
      S_HOLD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [TW+15:0] ring_mem [2**MAW];
   logic [TW+15:0] rd_data_ff;

   logic [AW-1:0]    widx_ff [tswtm_pkg::NUM_LINKS];
   logic [AW:0]      scnt_ff [tswtm_pkg::NUM_LINKS];
   logic [TW-1:0]    ftime_ff [tswtm_pkg::NUM_LINKS];
   logic             fseen_ff [tswtm_pkg::NUM_LINKS];

   tswtm_pkg::job_type cur_ff;
   logic [AW-1:0]  pos_ff;
   logic [AW:0]    left_ff;
   logic [TW-1:0]  lo_ff;
   logic [tswtm_pkg::SUM_W-1:0]  sum_ff;
   logic [tswtm_pkg::PKTS_W-1:0] cnt_ff;
   logic [tswtm_pkg::PROD_W-1:0] rem_ff;
   logic [tswtm_pkg::PROD_W-1:0] quo_ff;
   logic [5:0]    bit_ff;
   logic [31:0]   div_ff;

   logic [2:0]    o_status_ff;
   logic [tswtm_pkg::BYTES_W-1:0] o_bytes_ff;
   logic [tswtm_pkg::PKTS_W-1:0]  o_pkts_ff;
   logic [tswtm_pkg::RATE_W-1:0]  o_rate_ff;
   logic [TW-1:0] o_first_ff;
   logic          o_full_ff;

   logic          l;
   logic          valid_tcp;
   logic          out_ok;
   logic [TW-1:0] e_time;
   logic [15:0]   e_bytes;
   logic [tswtm_pkg::PROD_W+31:0] trial;

   assign l         = cur_ff.link;
   assign e_time    = rd_data_ff[TW+15:16];
   assign e_bytes   = rd_data_ff[15:0];
   assign valid_tcp = (cur_ff.status == tswtm_pkg::ST_STORED) ||
                      (cur_ff.status == tswtm_pkg::ST_PORT_MISS);
   assign job_take  = (state_ff == S_IDLE) && job_valid;
   assign trial     = {{32{1'b0}}, rem_ff};
   // The result register is free, or its beat leaves this cycle
   assign out_ok    = !o_full_ff || rsp_pop;

   assign rsp_empty          = !o_full_ff;
   assign rsp_status         = o_status_ff;
   assign rsp_window_bytes   = o_bytes_ff;
   assign rsp_window_packets = o_pkts_ff;
   assign rsp_bit_rate       = o_rate_ff;
   assign rsp_first_time     = o_first_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (job_valid) state_in = S_OUT;
         S_RD:   state_in = (left_ff == '0) ? S_MUL : S_CHK;
         S_CHK:  state_in = S_RD;
         S_MUL:  state_in = S_DIV;
         S_DIV:  if (bit_ff == '0) state_in = S_OUT;
         S_OUT:  if (out_ok) state_in = S_HOLD;
         S_HOLD: if (!o_full_ff || rsp_pop) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && job_valid && job.query) state_in = S_RD;
      if (state_ff == S_CHK &&
          (e_time < lo_ff && !(e_time > cur_ff.time_us))) state_in = S_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         o_full_ff <= 1'b0;
         for (int i = 0; i < tswtm_pkg::NUM_LINKS; i++) begin
            widx_ff[i]  <= '0;
            scnt_ff[i]  <= '0;
            ftime_ff[i] <= '0;
            fseen_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_pop && o_full_ff) o_full_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (job_valid) begin
               cur_ff  <= job;
               pos_ff  <= widx_ff[job.link] - 1'b1;
               left_ff <= scnt_ff[job.link];
               lo_ff   <= (job.time_us >= {16'd0, window_us}) ?
                          job.time_us - {16'd0, window_us} : '0;
               div_ff  <= (window_us == '0) ? 32'd1 : window_us;
               sum_ff  <= '0;
               cnt_ff  <= '0;
            end
            S_RD: begin
               rd_data_ff <= ring_mem[{l, pos_ff}];
               pos_ff     <= pos_ff - 1'b1;
               left_ff    <= left_ff - 1'b1;
            end
            S_CHK: if (!(e_time > cur_ff.time_us) && !(e_time < lo_ff)) begin
               sum_ff <= sum_ff + tswtm_pkg::SUM_W'(e_bytes);
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_MUL: begin
               rem_ff <= tswtm_pkg::PROD_W'(sum_ff) *
                         tswtm_pkg::PROD_W'(tswtm_pkg::BITS_PER_SEC);
               quo_ff <= '0;
               bit_ff <= 6'(tswtm_pkg::PROD_W - 1);
            end
            S_DIV: begin
               // Restoring divide, one quotient bit a cycle.
               if ((trial >> bit_ff) >= {{tswtm_pkg::PROD_W{1'b0}}, div_ff}) begin
                  rem_ff <= rem_ff - tswtm_pkg::PROD_W'({{tswtm_pkg::PROD_W{1'b0}},
                            div_ff} << bit_ff);
                  quo_ff[bit_ff] <= 1'b1;
               end
               bit_ff <= bit_ff - 1'b1;
            end
            S_OUT: if (out_ok) begin
               o_status_ff <= cur_ff.status;
               o_bytes_ff  <= cur_ff.query ? sum_ff[tswtm_pkg::BYTES_W-1:0] : '0;
               o_pkts_ff   <= cur_ff.query ? cnt_ff : '0;
               o_rate_ff   <= !cur_ff.query ? '0 :
                  (quo_ff[tswtm_pkg::PROD_W-1:tswtm_pkg::RATE_W] != '0) ?
                  '1 : quo_ff[tswtm_pkg::RATE_W-1:0];
               if (!cur_ff.query && valid_tcp && !fseen_ff[l]) begin
                  fseen_ff[l]  <= 1'b1;
                  ftime_ff[l]  <= cur_ff.time_us;
                  o_first_ff   <= cur_ff.time_us;
               end else begin
                  o_first_ff   <= fseen_ff[l] ? ftime_ff[l] : '0;
               end
               if (!cur_ff.query && cur_ff.status == tswtm_pkg::ST_STORED) begin
                  widx_ff[l] <= widx_ff[l] + 1'b1;
                  if (scnt_ff[l] != (AW+1)'(tswtm_pkg::RING_DEPTH))
                     scnt_ff[l] <= scnt_ff[l] + 1'b1;
               end
            end
            S_HOLD: if (!o_full_ff || rsp_pop) o_full_ff <= 1'b1;
            default: ;
         endcase
      end
      if (state_ff == S_OUT && out_ok && !cur_ff.query &&
          cur_ff.status == tswtm_pkg::ST_STORED)
         ring_mem[{l, widx_ff[l]}] <= {cur_ff.time_us, cur_ff.payload};
   end

`ifndef SYNTH
   a_pop_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && !o_full_ff) |=> o_full_ff)
      else $error("result beat lost");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff[0] <= (AW+1)'(tswtm_pkg::RING_DEPTH))
      else $error("stored count past ring depth");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |=> state_ff != S_IDLE) else $error("job taken but not started");
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (o_full_ff && !rsp_pop) |=> ($stable(o_status_ff) && $stable(o_rate_ff) &&
      $stable(o_first_ff))) else $error("waiting result beat changed");
`endif

endmodule

// ===== rtl/tcp_sliding_window_throughput_meter_unit.sv =====
// Top level of the sliding-window TCP throughput meter.
// Input queue: drive req_* fields with req_push while req_full is low; a
// beat is either a packet record or a throughput query for one of two links.
// Result queue: while rsp_empty is low the oldest result is on rsp_*; take
// it with rsp_pop. One result beat per input beat, in order.
// A packet passes the back end through dispatch, the result register and
// hand-off. A query walks the ring with one memory read and one compare
// per entry examined, stopping at the first entry older than the window,
// with one more read when the walk runs out of entries, then does one
// multiply and a 53-bit bit-serial divide. A four-entry job queue lets
// packets be accepted while the back end walks or the result waits.
// When rsp_pop stays low the back end holds its next result until the
// output register frees, the job queue fills, then req_full rises.
// Reset clears the queue, ring pointers, counts, first-packet times and
// loads the port filters 5051/5052 and a 2 s window. Ring contents are
// not cleared; only entries written since reset are ever read.
module tcp_sliding_window_throughput_meter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic                          req_link_id,
   input  logic [3:0]                    req_ip_header_words,
   input  logic [7:0]                    req_ip_protocol,
   input  logic [15:0]                   req_ip_total_length,
   input  logic [3:0]                    req_tcp_offset_words,
   input  logic [15:0]                   req_source_port,
   input  logic [tswtm_pkg::TIME_W-1:0]  req_time_us,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_status,
   output logic [tswtm_pkg::BYTES_W-1:0] rsp_window_bytes,
   output logic [tswtm_pkg::PKTS_W-1:0]  rsp_window_packets,
   output logic [tswtm_pkg::RATE_W-1:0]  rsp_bit_rate,
   output logic [tswtm_pkg::TIME_W-1:0]  rsp_first_time,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   logic [15:0] port0_ff, port1_ff;
   logic [31:0] window_ff;
   logic                job_valid, job_take;
   tswtm_pkg::job_type  job;

   always_ff @(posedge clock) begin
      if (reset) begin
         port0_ff  <= tswtm_pkg::PORT0_RESET;
         port1_ff  <= tswtm_pkg::PORT1_RESET;
         window_ff <= tswtm_pkg::WINDOW_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tswtm_pkg::REG_PORT0:  port0_ff  <= csr_data[15:0];
            tswtm_pkg::REG_PORT1:  port1_ff  <= csr_data[15:0];
            tswtm_pkg::REG_WINDOW: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tswtm_front u_front (
      .clock, .reset, .req_push, .req_full, .req_kind, .req_link_id,
      .req_ip_header_words, .req_ip_protocol, .req_ip_total_length,
      .req_tcp_offset_words, .req_source_port, .req_time_us,
      .port0(port0_ff), .port1(port1_ff),
      .job_valid, .job, .job_take
   );

   tswtm_back u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .window_us(window_ff),
      .rsp_empty, .rsp_pop, .rsp_status, .rsp_window_bytes,
      .rsp_window_packets, .rsp_bit_rate, .rsp_first_time
   );

endmodule
